>>> design/cuh_pkg.sv
package cuh_pkg;

   localparam int NUM_HIST = 7;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_BUMP_READ,
      ST_BUMP_WRITE,
      ST_CLEAR,
      ST_READ,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       mem_rd;
      logic       mem_wr_inc;
      logic       mem_clr;
      logic       next_hist;
      logic       record_upd;
      logic       finish;
      logic       out_take;
   } cmd_bus_type;

   // datapath to controller
   typedef struct packed {
      logic       do_sample;
      logic       do_record;
      logic       div_busy;
      logic       last_hist;
      logic       last_clear;
      logic       out_full;
   } status_type;

   localparam logic [31:0] PCT_SCALE = 32'd100;

endpackage

>>> design/channel_utilization_histogram.sv
// Channel utilization histogram. One item is worked on at a time. An interval sample has its
// seven percents computed in turn by one shared radix-2 divider (a start, the division steps
// and a take per percent; a percent with a zero divisor is set to zero without the divider),
// and while recording each histogram then has its bin bumped by a read and a write; an
// ignored sample goes straight to the result; a clear sweeps all 7*NUM_BINS bins, one per
// cycle. One more transfer is taken while a result waits; its result follows once the
// waiting one is taken. After reset a clearing pass zeroes all 7*NUM_BINS bins of the
// histogram memory (154 by default) before the first transfer is taken.
module channel_utilization_histogram import cuh_pkg::*; #(
   parameter int NUM_BINS  = 22,
   parameter int BIN_WIDTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_interval_us,
   input  logic [31:0] req_carrier_sense_busy,
   input  logic [31:0] req_modem_primary_busy,
   input  logic [31:0] req_edca_busy_total,
   input  logic [31:0] req_tx_own_total,
   input  logic [31:0] req_rx_own_total,
   input  logic [15:0] req_record_count,
   input  logic [2:0]  req_hist_select,
   input  logic [4:0]  req_bin_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_sample,
   output logic [7:0]  rsp_air_pct,
   output logic [7:0]  rsp_wifi_air_pct,
   output logic [7:0]  rsp_foreign_rx_wifi_pct,
   output logic [7:0]  rsp_own_pct,
   output logic [7:0]  rsp_non_wifi_pct,
   output logic [7:0]  rsp_foreign_pct,
   output logic [7:0]  rsp_foreign_busy_pct,
   output logic [15:0] rsp_bin_count,
   output logic        rsp_recording,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_bus_type ctl;
   status_type  stat;
   logic        util_en_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, util_en_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         util_en_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         util_en_ff <= csr_pwdata[0];
      end
   end

   cuh_control u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (cmd_type'(req_command)),
      .stat        (stat),
      .ctl         (ctl)
   );

   cuh_datapath #(.NUM_BINS(NUM_BINS), .BIN_WIDTH(BIN_WIDTH)) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .ctl                     (ctl),
      .stat                    (stat),
      .util_enable             (util_en_ff),
      .req_command             (req_command),
      .req_interval_us         (req_interval_us),
      .req_carrier_sense_busy  (req_carrier_sense_busy),
      .req_modem_primary_busy  (req_modem_primary_busy),
      .req_edca_busy_total     (req_edca_busy_total),
      .req_tx_own_total        (req_tx_own_total),
      .req_rx_own_total        (req_rx_own_total),
      .req_record_count        (req_record_count),
      .req_hist_select         (req_hist_select),
      .req_bin_index           (req_bin_index),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_valid_sample        (rsp_valid_sample),
      .rsp_air_pct             (rsp_air_pct),
      .rsp_wifi_air_pct        (rsp_wifi_air_pct),
      .rsp_foreign_rx_wifi_pct (rsp_foreign_rx_wifi_pct),
      .rsp_own_pct             (rsp_own_pct),
      .rsp_non_wifi_pct        (rsp_non_wifi_pct),
      .rsp_foreign_pct         (rsp_foreign_pct),
      .rsp_foreign_busy_pct    (rsp_foreign_busy_pct),
      .rsp_bin_count           (rsp_bin_count),
      .rsp_recording           (rsp_recording)
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count)
         && $stable(rsp_recording) && $stable(rsp_air_pct))
      else $error("waiting result changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_sample |-> rsp_air_pct == 8'd0 && rsp_own_pct == 8'd0)
      else $error("percent set without sample");

   a_single_finish: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> !ctl.finish) else $error("double finish");

endmodule

>>> design/cuh_divider.sv
module cuh_divider import cuh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[31:0], quo_ff[31]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step, one quotient bit a cycle
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> design/cuh_control.sv
module cuh_control import cuh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  cmd_type     req_command,
   input  status_type  stat,
   output cmd_bus_type ctl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:       state_in = stat.last_clear ? ST_IDLE : ST_INIT;
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_SAMPLE: state_in = ST_DIV_START;
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  CMD_READ:   state_in = ST_READ;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV_START: state_in = stat.do_sample ? ST_DIV_WAIT : ST_DONE;
         ST_DIV_WAIT: begin
            if (!stat.div_busy) begin
               if (!stat.last_hist)  state_in = ST_DIV_START;
               else if (stat.do_record) state_in = ST_BUMP_READ;
               else                  state_in = ST_DONE;
            end
         end
         ST_BUMP_READ:  state_in = ST_BUMP_WRITE;
         ST_BUMP_WRITE: state_in = stat.last_hist ? ST_DONE : ST_BUMP_READ;
         ST_CLEAR:      state_in = stat.last_clear ? ST_DONE : ST_CLEAR;
         ST_READ:       state_in = ST_READ_WAIT;
         ST_READ_WAIT:  state_in = ST_DONE;
         // wait here while the previous result is still unclaimed
         ST_DONE:       state_in = stat.out_full ? ST_DONE : ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT:       ctl.mem_clr = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_DIV_START: begin
            ctl.div_start = stat.do_sample;
         end
         ST_DIV_WAIT: begin
            ctl.out_take  = !stat.div_busy;
            ctl.next_hist = !stat.div_busy;
         end
         ST_BUMP_READ:  ctl.mem_rd = 1'b1;
         ST_BUMP_WRITE: begin
            ctl.mem_wr_inc = 1'b1;
            ctl.next_hist  = 1'b1;
         end
         ST_CLEAR:      ctl.mem_clr = 1'b1;
         ST_READ:       ctl.mem_rd = 1'b1;
         ST_READ_WAIT:  ctl.mem_rd = 1'b0;
         ST_DONE: begin
            ctl.record_upd = !stat.out_full;
            ctl.finish     = !stat.out_full;
         end
         default: ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/cuh_datapath.sv
module cuh_datapath import cuh_pkg::*; #(
   parameter int NUM_BINS  = 22,
   parameter int BIN_WIDTH = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_bus_type ctl,
   output status_type  stat,
   input  logic        util_enable,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_interval_us,
   input  logic [31:0] req_carrier_sense_busy,
   input  logic [31:0] req_modem_primary_busy,
   input  logic [31:0] req_edca_busy_total,
   input  logic [31:0] req_tx_own_total,
   input  logic [31:0] req_rx_own_total,
   input  logic [15:0] req_record_count,
   input  logic [2:0]  req_hist_select,
   input  logic [4:0]  req_bin_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_sample,
   output logic [7:0]  rsp_air_pct,
   output logic [7:0]  rsp_wifi_air_pct,
   output logic [7:0]  rsp_foreign_rx_wifi_pct,
   output logic [7:0]  rsp_own_pct,
   output logic [7:0]  rsp_non_wifi_pct,
   output logic [7:0]  rsp_foreign_pct,
   output logic [7:0]  rsp_foreign_busy_pct,
   output logic [15:0] rsp_bin_count,
   output logic        rsp_recording
);

   localparam int DEPTH = NUM_HIST * NUM_BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(NUM_BINS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;

   cmd_type     cmd_ff;
   logic [31:0] ivl_ff, cs_ff, mdm_ff, edca_ff, tx_ff, rx_ff;
   logic [15:0] count_ff;
   logic [2:0]  sel_ff;
   logic [4:0]  bin_ff;
   logic [31:0] edca_base_ff, tx_base_ff, rx_base_ff;
   logic [15:0] left_ff;
   logic        active_ff;
   logic        sample_ff, rec_ff;
   logic [2:0]  hist_ff;
   logic [31:0] pct_ff [NUM_HIST];
   logic [AW-1:0] clr_ff;
   logic        full_ff;
   logic        vs_ff;
   logic [7:0]  pct_out_ff [NUM_HIST];
   logic [15:0] bc_ff;
   logic        recd_ff;
   logic        read_ok_ff;

   logic [31:0] dtx, drx, dedca, own, foreign, rest;
   logic [31:0] num, den, quo;
   logic        div_busy, div_go;
   logic [31:0] p;
   logic [BW-1:0] bin_sel;
   logic [AW-1:0] bump_addr, read_addr;
   logic        active_in;
   logic [15:0] left_in;

   assign dtx     = tx_ff - tx_base_ff;
   assign drx     = rx_ff - rx_base_ff;
   assign dedca   = edca_ff - edca_base_ff;
   assign own     = dtx + drx;
   assign foreign = dedca - drx;
   assign rest    = ivl_ff - own;

   always_comb begin
      case (hist_ff)
         3'd0:    num = cs_ff + dtx;
         3'd1:    num = mdm_ff + dtx;
         3'd2:    num = mdm_ff - drx;
         3'd3:    num = own;
         3'd4:    num = dedca - mdm_ff;
         default: num = foreign;
      endcase
      den = (hist_ff == 3'd6) ? rest : ivl_ff;
   end

   // 32-bit wrapped product by 100 as shifts and adds
   logic [31:0] num100;
   assign num100 = (num << 6) + (num << 5) + (num << 2);
   assign div_go = ctl.div_start && (den != 32'd0);

   cuh_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (num100),
      .divisor  (den),
      .busy     (div_busy),
      .quotient (quo)
   );

   // bin of the current histogram's percent
   assign p = pct_ff[hist_ff];
   always_comb begin
      logic [31:0] b;
      logic [31:0] pm1;
      b   = '0;
      pm1 = p - 32'd1;
      if (p == 32'd0) begin
         b = '0;
      end else if (p > PCT_SCALE) begin
         b = 32'(NUM_BINS - 1);
      end else begin
         // one plus the number of whole bin widths below p, clamped to the last bin
         b = 32'd1;
         for (int k = 1; k < NUM_BINS - 1; k++) begin
            if (pm1 >= 32'(k * BIN_WIDTH)) b = 32'(k + 1);
         end
      end
      bin_sel = b[BW-1:0];
   end

   assign bump_addr = AW'(hist_ff * NUM_BINS) + AW'(bin_sel);
   assign read_addr = AW'(sel_ff * NUM_BINS) + AW'(bin_ff);

   always_comb begin
      stat.do_sample  = sample_ff;
      stat.do_record  = rec_ff;
      stat.div_busy   = div_busy;
      stat.last_hist  = (hist_ff == 3'(NUM_HIST - 1));
      stat.last_clear = (clr_ff == LAST_ADDR);
      stat.out_full   = full_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_clr) begin
         mem[clr_ff] <= '0;
      end else if (ctl.mem_wr_inc) begin
         mem[bump_addr] <= rd_data_ff + 16'd1;
      end
      if (ctl.mem_rd) begin
         rd_data_ff <= (cmd_ff == CMD_READ) ? mem[read_addr] : mem[bump_addr];
      end
   end

   // recording state after a finished item
   always_comb begin
      active_in = active_ff;
      left_in   = left_ff;
      case (cmd_ff)
         CMD_SAMPLE: begin
            if (sample_ff) begin
               if (rec_ff) left_in = left_ff - 16'd1;
               if (left_in == 16'd0) active_in = 1'b0;
            end
         end
         CMD_RECORD: begin
            left_in   = count_ff;
            active_in = (count_ff != 16'd0);
         end
         default: active_in = active_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= cmd_type'(req_command);
         ivl_ff   <= req_interval_us;
         cs_ff    <= req_carrier_sense_busy;
         mdm_ff   <= req_modem_primary_busy;
         edca_ff  <= req_edca_busy_total;
         tx_ff    <= req_tx_own_total;
         rx_ff    <= req_rx_own_total;
         count_ff <= req_record_count;
         sel_ff   <= req_hist_select;
         bin_ff   <= req_bin_index;
         read_ok_ff <= (req_hist_select < 3'(NUM_HIST)) && (32'(req_bin_index) < NUM_BINS);
         sample_ff <= (req_command == CMD_SAMPLE) && (req_interval_us != 32'd0)
                      && (util_enable || active_ff);
         rec_ff   <= active_ff && (left_ff != 16'd0);
      end
      if (ctl.div_start && !div_go) begin
         pct_ff[hist_ff] <= '0;
      end
      if (ctl.out_take && den != 32'd0) begin
         pct_ff[hist_ff] <= quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edca_base_ff <= '0;
         tx_base_ff   <= '0;
         rx_base_ff   <= '0;
         left_ff      <= '0;
         active_ff    <= 1'b0;
         hist_ff      <= '0;
         clr_ff       <= '0;
         full_ff      <= 1'b0;
      end else begin
         if (ctl.load) begin
            hist_ff <= '0;
            clr_ff  <= '0;
         end
         if (ctl.next_hist && !stat.last_hist) hist_ff <= hist_ff + 3'd1;
         else if (ctl.next_hist && ctl.out_take) hist_ff <= '0;
         if (ctl.mem_clr) clr_ff <= clr_ff + AW'(1);
         if (ctl.record_upd) begin
            left_ff   <= left_in;
            active_ff <= active_in;
            if (sample_ff || (cmd_ff == CMD_RECORD && count_ff != 16'd0)) begin
               edca_base_ff <= edca_ff;
               tx_base_ff   <= tx_ff;
               rx_base_ff   <= rx_ff;
            end
         end
         if (ctl.finish) full_ff <= 1'b1;
         else if (rsp_ready) full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         vs_ff   <= sample_ff;
         for (int i = 0; i < NUM_HIST; i++) begin
            pct_out_ff[i] <= !sample_ff ? 8'd0
                           : (pct_ff[i] > 32'd255) ? 8'd255 : pct_ff[i][7:0];
         end
         bc_ff   <= (cmd_ff == CMD_READ && read_ok_ff) ? rd_data_ff : 16'd0;
         recd_ff <= active_in;
      end
   end

   assign rsp_valid               = full_ff;
   assign rsp_valid_sample        = vs_ff;
   assign rsp_air_pct             = pct_out_ff[0];
   assign rsp_wifi_air_pct        = pct_out_ff[1];
   assign rsp_foreign_rx_wifi_pct = pct_out_ff[2];
   assign rsp_own_pct             = pct_out_ff[3];
   assign rsp_non_wifi_pct        = pct_out_ff[4];
   assign rsp_foreign_pct         = pct_out_ff[5];
   assign rsp_foreign_busy_pct    = pct_out_ff[6];
   assign rsp_bin_count           = bc_ff;
   assign rsp_recording           = recd_ff;

endmodule
